### design/bounded_stack_with_average_assert.svh
// Assertion macros for the stack design files; only bsa_back includes them.
// Included by name; depends on nothing else.
`ifndef BOUNDED_STACK_WITH_AVERAGE_ASSERT_SVH
`define BOUNDED_STACK_WITH_AVERAGE_ASSERT_SVH
`ifndef SYNTHESIS
`define BSA_ASSERT_IMPLIES(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);
`define BSA_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BSA_ASSERT_IMPLIES(lbl, ck, rs, ante, cons, msg)
`define BSA_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

### design/bsa_pkg.sv
// Types and constants shared by the stack with running mean.
// No dependencies.
package bsa_pkg;

  localparam int IN_W        = 32;
  localparam int MEAN_W      = 40;
  localparam int COUNT_OUT_W = 9;
  localparam int ERR_W       = 2;
  // The operation queue depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_code_t;

  typedef enum logic [1:0] {
    OP_PUSH       = 2'd0,
    OP_POP        = 2'd1,
    OP_POP_EMPTY  = 2'd2,
    OP_PUSH_FULL  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [IN_W-1:0]   value;
  } op_t;

endpackage

### design/bsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/bsa_front.sv
// Front end: takes items, tracks the fill level and classifies each item.
// Depends on bsa_pkg.
module bsa_front
  import bsa_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic            action,
  input  logic [IN_W-1:0] push_value,
  input  logic            q_full,
  output logic            q_push,
  output op_t             q_op
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign q_push = push && !q_full;

  always_comb begin
    count_next     = count;
    q_op.value     = push_value;
    q_op.kind      = OP_PUSH;
    if (!action) begin
      if (count == CNT_W'(DEPTH)) begin
        q_op.kind = OP_PUSH_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (count == '0) begin
        q_op.kind = OP_POP_EMPTY;
      end else begin
        q_op.kind  = OP_POP;
        count_next = count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (q_push) begin
      count <= count_next;
    end
  end

endmodule

### design/bsa_queue.sv
// Short queue of classified operations between the front and back ends.
// Depends on bsa_pkg.
module bsa_queue
  import bsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  op_t  wr_op,
  output logic full,
  input  logic rd,
  output op_t  rd_op,
  output logic empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign rd_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### design/bsa_back.sv
// Back end: stack memory, running sum, serial mean divider and result register.
// Depends on bsa_pkg, bsa_ram and the assertion macro header.
`include "bounded_stack_with_average_assert.svh"
module bsa_back
  import bsa_pkg::*;
#(
  parameter int DEPTH         = 256,
  parameter int VALUE_BITS    = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  op_t                    q_op,
  output logic                   q_pop,
  output logic                   empty,
  input  logic                   pop,
  output logic                   is_empty_flag,
  output logic [IN_W-1:0]        top_value,
  output logic                   top_valid,
  output logic [MEAN_W-1:0]      mean_value,
  output logic                   mean_valid,
  output logic [ERR_W-1:0]       error_code,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int AW     = $clog2(DEPTH);
  localparam int SUM_W  = VALUE_BITS + CNT_W;
  localparam int DIV_W  = SUM_W + FRACTION_BITS;
  localparam int STEP_W = $clog2(DIV_W);
  localparam int MW     = (DIV_W > MEAN_W) ? DIV_W : MEAN_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t                        state, state_next;
  logic [CNT_W-1:0]              count, count_next;
  logic signed [SUM_W-1:0]       sum, sum_next;
  logic signed [VALUE_BITS-1:0]  top_reg, top_next;
  err_code_t                     err, err_next;
  logic                          neg, neg_next;
  logic [DIV_W-1:0]              quo, quo_next;
  logic [CNT_W-1:0]              rem, rem_next;
  logic [STEP_W-1:0]             step, step_next;
  logic                          out_valid;
  logic                          out_load;

  logic signed [VALUE_BITS-1:0]  op_val;
  logic [SUM_W-1:0]              mag;
  logic [CNT_W:0]                rem_sh;
  logic [CNT_W:0]                rem_diff;
  logic                          ge;
  logic [MW-1:0]                 quo_ext;
  logic [MW-1:0]                 mean_full;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr;
  logic [VALUE_BITS-1:0]         ram_rdata;

  bsa_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (op_val),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign op_val    = q_op.value[VALUE_BITS-1:0];
  assign ram_waddr = AW'(count);
  assign ram_raddr = AW'(count - CNT_W'(2));
  assign mag       = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign rem_sh    = {rem, quo[DIV_W-1]};
  assign rem_diff  = rem_sh - {1'b0, count};
  assign ge        = rem_sh >= {1'b0, count};
  assign quo_ext   = MW'(quo);
  assign mean_full = neg ? (~quo_ext + MW'(1)) : quo_ext;
  assign empty     = !out_valid;

  always_comb begin
    state_next = state;
    count_next = count;
    sum_next   = sum;
    top_next   = top_reg;
    err_next   = err;
    neg_next   = neg;
    quo_next   = quo;
    rem_next   = rem;
    step_next  = step;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          err_next   = ERR_NONE;
          state_next = ST_LOAD;
          unique case (q_op.kind) inside
            OP_PUSH: begin
              ram_we     = 1'b1;
              count_next = count + CNT_W'(1);
              sum_next   = sum + SUM_W'(op_val);
              top_next   = op_val;
            end
            OP_POP: begin
              count_next = count - CNT_W'(1);
              sum_next   = sum - SUM_W'(top_reg);
              if (count > CNT_W'(1)) begin
                state_next = ST_READ;
              end
            end
            OP_POP_EMPTY, OP_PUSH_FULL: begin
              err_next = (q_op.kind == OP_POP_EMPTY) ? ERR_POP_EMPTY : ERR_PUSH_FULL;
            end
          endcase
        end
      end
      ST_READ: begin
        top_next   = ram_rdata;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        neg_next   = sum[SUM_W-1];
        quo_next   = DIV_W'(mag) << FRACTION_BITS;
        rem_next   = '0;
        step_next  = '0;
        state_next = (count == '0) ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        rem_next  = ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_next  = {quo[DIV_W-2:0], ge};
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(DIV_W - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      sum       <= '0;
      err       <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      sum   <= sum_next;
      err   <= err_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_reg <= top_next;
    neg     <= neg_next;
    quo     <= quo_next;
    rem     <= rem_next;
    step    <= step_next;
    if (out_load) begin
      is_empty_flag <= count == '0;
      top_valid     <= count != '0;
      mean_valid    <= count != '0;
      top_value     <= (count != '0) ? IN_W'(top_reg) : '0;
      mean_value    <= (count != '0) ? mean_full[MEAN_W-1:0] : '0;
      error_code    <= err;
      entry_count   <= COUNT_OUT_W'(count);
    end
  end

  `BSA_ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "fill count above depth")
  `BSA_ASSERT_IMPLIES(a_div_nonzero, clk, rst, state == ST_DIV, count != '0, "division by an empty count")
  `BSA_ASSERT_NEXT(a_out_done, clk, rst, out_load, (state == ST_IDLE) && out_valid, "result transfer lost")

endmodule

### design/bounded_stack_with_average.sv
// Top level of the bounded stack with running mean.
// Depends on bsa_pkg, bsa_front, bsa_queue and bsa_back.
//
// Channel   Direction  Handshake          Payload
// input     in         push / full        action, push_value
// result    out        pop / empty        is_empty_flag, top_value, top_valid,
//                                         mean_value, mean_valid, error_code,
//                                         entry_count
//
// The back end takes one item at a time; its mean divider works on DIV_W bits,
// DIV_W being VALUE_BITS + clog2(DEPTH + 1) + FRACTION_BITS (49 at the
// defaults), and yields one quotient bit per cycle. A pop that leaves entries
// adds a memory read, and an item that leaves the stack empty skips the divider.
// A held result stalls the back end; two classified items can wait in the queue.
// Reset is synchronous and empties the stack; no clearing pass is needed.
module bounded_stack_with_average
  import bsa_pkg::*;
#(
  parameter int DEPTH         = 256,
  parameter int VALUE_BITS    = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic                   action,
  input  logic [IN_W-1:0]        push_value,
  output logic                   empty,
  input  logic                   pop,
  output logic                   is_empty_flag,
  output logic [IN_W-1:0]        top_value,
  output logic                   top_valid,
  output logic [MEAN_W-1:0]      mean_value,
  output logic                   mean_valid,
  output logic [ERR_W-1:0]       error_code,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  op_t  wr_op;
  op_t  rd_op;

  assign full = q_full;

  bsa_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .action     (action),
    .push_value (push_value),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (wr_op)
  );

  bsa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wr_op (wr_op),
    .full  (q_full),
    .rd    (q_pop),
    .rd_op (rd_op),
    .empty (q_empty)
  );

  bsa_back #(
    .DEPTH         (DEPTH),
    .VALUE_BITS    (VALUE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_op          (rd_op),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .is_empty_flag (is_empty_flag),
    .top_value     (top_value),
    .top_valid     (top_valid),
    .mean_value    (mean_value),
    .mean_valid    (mean_valid),
    .error_code    (error_code),
    .entry_count   (entry_count)
  );

endmodule
